>>> rtl/core/uhid_pkg.sv
`timescale 1ns / 1ps

package uhid_pkg;

	localparam int REPORT_BYTES_MAX_DEF = 64;
	localparam int CHANNEL_COUNT_DEF = 16;

	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 32;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [2:0] {
		ACT_START = 3'd0,
		ACT_STEP = 3'd1,
		ACT_TICK = 3'd2,
		ACT_DISCONNECT = 3'd3,
		ACT_QUEUE_OUT = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		CMD_NONE = 3'd0,
		CMD_OPEN = 3'd1,
		CMD_START_IN = 3'd2,
		CMD_CLEAR_HALT = 3'd3,
		CMD_SET_REPORT = 3'd4
	} command_t;

	typedef enum logic [2:0] {
		XFER_PENDING = 3'd0,
		XFER_DONE = 3'd1,
		XFER_NAK = 3'd2,
		XFER_STALL = 3'd3,
		XFER_ERROR = 3'd4
	} xfer_t;

	typedef enum logic [1:0] {
		REQ_OK = 2'd0,
		REQ_BUSY = 2'd1,
		REQ_FAIL = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		STS_OK = 3'd0,
		STS_IN_PROGRESS = 3'd1,
		STS_BUSY = 3'd2,
		STS_IO_ERROR = 3'd3,
		STS_NO_DEVICE = 3'd4,
		STS_INVALID = 3'd5,
		STS_REQ_FAILED = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		REG_HS_MODE = 3'd0,
		REG_POLL_INTERVAL = 3'd1,
		REG_MIN_REPORT = 3'd2,
		REG_MAX_PACKET = 3'd3,
		REG_DEVICE_ADDR = 3'd4,
		REG_ENDPOINT_ADDR = 3'd5,
		REG_INTERFACE_NUM = 3'd6
	} reg_index_t;

	typedef enum logic [5:0] {
		ST_EXIT = 6'b000001,
		ST_INIT = 6'b000010,
		ST_POLL = 6'b000100,
		ST_WAIT = 6'b001000,
		ST_STALL = 6'b010000,
		ST_OUT = 6'b100000
	} state_t;

endpackage

>>> rtl/core/usb_hid_interrupt_poll_fsm.sv
`timescale 1ns / 1ps
// The input transfer is captured in the input register and its result in the result register, where it is offered.
// Throughput: one event per cycle while the result side takes every transfer.
// The sequencer state is updated once per event as it moves from the input to the result register.
// Reset (arst_n low, asynchronous) puts the machine in the exit state, clears the toggle,
// timer, pending out length and held channel, and loads the register defaults.

module usb_hid_interrupt_poll_fsm #(
	parameter int REPORT_BYTES_MAX = uhid_pkg::REPORT_BYTES_MAX_DEF,
	parameter int CHANNEL_COUNT = uhid_pkg::CHANNEL_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// alloc_ok, alloc_channel, start_ok, transfer_result, transfer_length,
	// request_result, report_size, zero fill
	input logic [uhid_pkg::S_TDATA_W-1:0] s_tdata,
	// action
	input logic [uhid_pkg::S_TUSER_W-1:0] s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// command, data_pid, channel, free_channel, deliver_report, report_length,
	// out_report_length, status, running, accepted, zero fill
	output logic [uhid_pkg::M_TDATA_W-1:0] m_tdata,
	input logic cfg_wen,
	input logic [uhid_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [uhid_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	localparam logic [10:0] RBM = 11'(REPORT_BYTES_MAX);
	localparam logic [6:0] CHN = 7'(CHANNEL_COUNT);

	logic hs_mode_q;
	logic [7:0] poll_interval_q;
	logic [6:0] min_report_q;
	logic [6:0] max_packet_q;
	logic [6:0] device_addr_q;
	logic [7:0] endpoint_addr_q;
	logic [7:0] interface_num_q;

	uhid_pkg::state_t st_q, st_d;
	uhid_pkg::status_t last_q, last_d;
	logic tog_q, tog_d;
	logic [3:0] hch_q, hch_d;
	logic held_q, held_d;
	logic [15:0] timer_q, timer_d;
	logic [6:0] pend_q, pend_d;

	logic valid_s1;
	logic [uhid_pkg::S_TDATA_W-1:0] data_s1;
	logic [uhid_pkg::S_TUSER_W-1:0] user_s1;
	logic out_valid_q;
	logic [uhid_pkg::M_TDATA_W-1:0] out_q;
	logic advance;

	logic alloc_ok;
	logic [3:0] alloc_channel;
	logic start_ok;
	logic [2:0] transfer_result;
	logic [6:0] transfer_length;
	logic [1:0] request_result;
	logic [15:0] report_size;

	uhid_pkg::command_t cmd;
	logic pid, freed, deliver, accepted, running;
	logic [3:0] chan;
	logic [6:0] rlen, olen;
	uhid_pkg::status_t status;
	logic [15:0] reload;

	assign alloc_ok = data_s1[0];
	assign alloc_channel = data_s1[4:1];
	assign start_ok = data_s1[5];
	assign transfer_result = data_s1[8:6];
	assign transfer_length = data_s1[15:9];
	assign request_result = data_s1[17:16];
	assign report_size = data_s1[33:18];

	assign advance = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_mode_q <= 1'b0;
			poll_interval_q <= 8'd1;
			min_report_q <= 7'd0;
			max_packet_q <= 7'd8;
			device_addr_q <= 7'd0;
			endpoint_addr_q <= 8'd129;
			interface_num_q <= 8'd0;
		end else if (cfg_wen) begin
			case (cfg_index)
				uhid_pkg::REG_HS_MODE: hs_mode_q <= cfg_wdata[0];
				uhid_pkg::REG_POLL_INTERVAL: poll_interval_q <= cfg_wdata;
				uhid_pkg::REG_MIN_REPORT: min_report_q <= cfg_wdata[6:0];
				uhid_pkg::REG_MAX_PACKET: max_packet_q <= cfg_wdata[6:0];
				uhid_pkg::REG_DEVICE_ADDR: device_addr_q <= cfg_wdata[6:0];
				uhid_pkg::REG_ENDPOINT_ADDR: endpoint_addr_q <= cfg_wdata;
				uhid_pkg::REG_INTERFACE_NUM: interface_num_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Addressing registers are stored but drive no output; their parity is masked to zero in the result.
	logic addr_unused;
	assign addr_unused = ^{device_addr_q, endpoint_addr_q, interface_num_q};

	always_comb begin
		if (!hs_mode_q) begin
			reload = {8'd0, poll_interval_q};
		end else if (poll_interval_q == 8'd0) begin
			reload = 16'd1;
		end else if (poll_interval_q > 8'd16) begin
			reload = 16'h8000;
		end else begin
			reload = 16'd1 << (poll_interval_q[4:0] - 5'd1);
		end
	end

	always_comb begin
		logic bad;
		logic free_on_exit;
		logic [6:0] len;
		logic [15:0] sz;

		st_d = st_q;
		last_d = last_q;
		tog_d = tog_q;
		hch_d = hch_q;
		held_d = held_q;
		timer_d = timer_q;
		pend_d = pend_q;
		cmd = uhid_pkg::CMD_NONE;
		pid = 1'b0;
		chan = 4'd0;
		freed = 1'b0;
		deliver = 1'b0;
		rlen = 7'd0;
		olen = 7'd0;
		status = last_q;
		accepted = 1'b0;
		free_on_exit = 1'b0;
		bad = ({4'd0, max_packet_q} > RBM) || (max_packet_q < min_report_q) ||
			(poll_interval_q == 8'd0) || (hs_mode_q && poll_interval_q > 8'd16);
		len = transfer_length;
		if (len > max_packet_q) begin
			len = max_packet_q;
		end
		if ({4'd0, len} > RBM) begin
			len = RBM[6:0];
		end
		sz = report_size;
		if (sz > {5'd0, RBM}) begin
			sz = {5'd0, RBM};
		end
		if (sz > 16'd127) begin
			sz = 16'd127;
		end

		case (user_s1)
			uhid_pkg::ACT_START: begin
				if (bad) begin
					status = uhid_pkg::STS_INVALID;
				end else begin
					if (held_q) begin
						freed = 1'b1;
						chan = hch_q;
						held_d = 1'b0;
					end
					st_d = uhid_pkg::ST_INIT;
					last_d = uhid_pkg::STS_OK;
					tog_d = 1'b0;
					timer_d = 16'd1;
					pend_d = 7'd0;
					status = uhid_pkg::STS_OK;
					accepted = 1'b1;
				end
			end
			uhid_pkg::ACT_STEP: begin
				free_on_exit = 1'b1;
				case (st_q)
					uhid_pkg::ST_INIT: begin
						if (alloc_ok && ({3'd0, alloc_channel} < CHN)) begin
							hch_d = alloc_channel;
							held_d = 1'b1;
							cmd = uhid_pkg::CMD_OPEN;
							chan = alloc_channel;
							timer_d = 16'd1;
							last_d = uhid_pkg::STS_OK;
							tog_d = 1'b0;
							st_d = (pend_q != 7'd0) ? uhid_pkg::ST_OUT : uhid_pkg::ST_POLL;
						end else begin
							last_d = uhid_pkg::STS_BUSY;
							st_d = uhid_pkg::ST_EXIT;
						end
					end
					uhid_pkg::ST_POLL: begin
						if (timer_q == 16'd0) begin
							cmd = uhid_pkg::CMD_START_IN;
							pid = tog_q;
							chan = hch_q;
							if (start_ok) begin
								timer_d = reload;
								last_d = uhid_pkg::STS_IN_PROGRESS;
								st_d = uhid_pkg::ST_WAIT;
							end else begin
								last_d = uhid_pkg::STS_IO_ERROR;
								st_d = uhid_pkg::ST_EXIT;
							end
						end
					end
					uhid_pkg::ST_WAIT: begin
						case (transfer_result)
							uhid_pkg::XFER_DONE: begin
								tog_d = !tog_q;
								last_d = uhid_pkg::STS_OK;
								st_d = uhid_pkg::ST_POLL;
								if (len >= min_report_q) begin
									deliver = 1'b1;
									rlen = len;
									if (pend_q != 7'd0) begin
										st_d = uhid_pkg::ST_OUT;
									end
								end
							end
							uhid_pkg::XFER_NAK: st_d = uhid_pkg::ST_POLL;
							uhid_pkg::XFER_STALL: st_d = uhid_pkg::ST_STALL;
							uhid_pkg::XFER_ERROR: begin
								last_d = uhid_pkg::STS_IO_ERROR;
								st_d = uhid_pkg::ST_EXIT;
							end
							default: ;
						endcase
					end
					uhid_pkg::ST_STALL, uhid_pkg::ST_OUT: begin
						chan = hch_q;
						if (st_q == uhid_pkg::ST_STALL) begin
							cmd = uhid_pkg::CMD_CLEAR_HALT;
							tog_d = 1'b0;
						end else begin
							cmd = uhid_pkg::CMD_SET_REPORT;
							olen = pend_q;
						end
						case (request_result)
							uhid_pkg::REQ_OK: begin
								last_d = uhid_pkg::STS_OK;
								st_d = uhid_pkg::ST_POLL;
								if (st_q == uhid_pkg::ST_OUT) begin
									pend_d = 7'd0;
								end
							end
							uhid_pkg::REQ_BUSY: last_d = uhid_pkg::STS_IN_PROGRESS;
							default: begin
								last_d = uhid_pkg::STS_REQ_FAILED;
								st_d = uhid_pkg::ST_EXIT;
							end
						endcase
					end
					default: st_d = uhid_pkg::ST_EXIT;
				endcase
				status = last_d;
			end
			uhid_pkg::ACT_TICK: begin
				if (timer_q != 16'd0) begin
					timer_d = timer_q - 16'd1;
				end
			end
			uhid_pkg::ACT_DISCONNECT: begin
				free_on_exit = 1'b1;
				st_d = uhid_pkg::ST_EXIT;
				last_d = uhid_pkg::STS_NO_DEVICE;
				deliver = 1'b1;
				status = uhid_pkg::STS_NO_DEVICE;
			end
			uhid_pkg::ACT_QUEUE_OUT: begin
				if (pend_q != 7'd0) begin
					status = uhid_pkg::STS_BUSY;
				end else begin
					pend_d = sz[6:0];
					status = uhid_pkg::STS_OK;
					accepted = 1'b1;
				end
			end
			default: ;
		endcase

		if (free_on_exit && st_d == uhid_pkg::ST_EXIT && held_d) begin
			freed = 1'b1;
			chan = hch_d;
			held_d = 1'b0;
		end
		running = (st_d != uhid_pkg::ST_EXIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			st_q <= uhid_pkg::ST_EXIT;
			last_q <= uhid_pkg::STS_OK;
			tog_q <= 1'b0;
			hch_q <= 4'd0;
			held_q <= 1'b0;
			timer_q <= 16'd0;
			pend_q <= 7'd0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				st_q <= st_d;
				last_q <= last_d;
				tog_q <= tog_d;
				hch_q <= hch_d;
				held_q <= held_d;
				timer_q <= timer_d;
				pend_q <= pend_d;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			user_s1 <= s_tuser;
		end
		if (advance) begin
			out_q <= {2'b00, addr_unused & 1'b0, accepted, running, status, olen, rlen,
				deliver, freed, chan, pid, cmd};
		end
	end

	a_free_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && freed |=> !held_q)
		else $error("held channel survives a release");

	a_report_fits: assert property (@(posedge clk) disable iff (!arst_n)
		advance && deliver && rlen != 7'd0 |-> rlen <= max_packet_q && rlen >= min_report_q)
		else $error("delivered report length out of bounds");

	a_stall_only: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && out_valid_q && !m_tready)
		else $error("input held off without a stalled result");

	a_start_in_poll: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cmd == uhid_pkg::CMD_START_IN |->
			st_q == uhid_pkg::ST_POLL && timer_q == 16'd0)
		else $error("IN transaction started outside an expired poll");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{4'd0, pend_q} <= RBM)
		else $error("pending out report exceeds buffer size");

endmodule
